### rtl/core/pei_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the particle Euler integrator.
// No dependencies; every other file in rtl/core uses this package.
package pei_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths of the item formats.
  localparam int AGE_W  = 31;
  localparam int VAL_W  = 32;
  localparam int DRAG_W = 31;
  localparam int DT_W   = 17;

  // Reset value of the time step register.
  localparam logic [DT_W-1:0] DT_RESET = 17'd1092;

  // Register stages from accepted item to result strobe.
  localparam int PIPE_DEPTH = 6;

  // One input item: a live particle record.
  typedef struct packed {
    logic        [AGE_W-1:0]  age_in;
    logic        [AGE_W-1:0]  lifetime;
    logic signed [VAL_W-1:0]  pos_x_in;
    logic signed [VAL_W-1:0]  pos_y_in;
    logic signed [VAL_W-1:0]  pos_z_in;
    logic signed [VAL_W-1:0]  vel_x_in;
    logic signed [VAL_W-1:0]  vel_y_in;
    logic signed [VAL_W-1:0]  vel_z_in;
    logic signed [VAL_W-1:0]  grav_x;
    logic signed [VAL_W-1:0]  grav_y;
    logic signed [VAL_W-1:0]  grav_z;
    logic        [DRAG_W-1:0] drag_coef;
  } in_item_t;

  // One result item: the advanced record.
  typedef struct packed {
    logic                    still_alive;
    logic        [AGE_W-1:0] age_out;
    logic signed [VAL_W-1:0] pos_x_out;
    logic signed [VAL_W-1:0] pos_y_out;
    logic signed [VAL_W-1:0] pos_z_out;
    logic signed [VAL_W-1:0] vel_x_out;
    logic signed [VAL_W-1:0] vel_y_out;
    logic signed [VAL_W-1:0] vel_z_out;
  } out_item_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi) begin
      sat32 = hi[VAL_W-1:0];
    end else if (x < lo) begin
      sat32 = lo[VAL_W-1:0];
    end else begin
      sat32 = x[VAL_W-1:0];
    end
  endfunction

endpackage

### rtl/core/pei_drag_factor.sv
`timescale 1ns / 1ps
// Two-stage drag factor unit: k = max(0, 1 - floor(drag * dt)).
// Depends on pei_pkg for field widths.
module pei_drag_factor #(
  parameter int FRAC_BITS = pei_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic [pei_pkg::DRAG_W-1:0]    drag_coef,
  input  logic [pei_pkg::DT_W-1:0]      dt,
  output logic [FRAC_BITS:0]            k_factor
);

  localparam int DPW = pei_pkg::DRAG_W + pei_pkg::DT_W;
  localparam int KW  = FRAC_BITS + 1;
  localparam logic [DPW-1:0] ONE_EXT = DPW'(1) << FRAC_BITS;

  logic [DPW-1:0] dprod_r;
  logic [DPW-1:0] dsh;
  logic [KW-1:0]  k_nxt;
  logic [KW-1:0]  k_r;

  // Stage one: exact product of drag and time step.
  always_ff @(posedge clk) begin
    dprod_r <= DPW'(drag_coef) * DPW'(dt);
  end

  // Stage two: one minus the truncated product, clamped at zero.
  always_comb begin
    dsh = dprod_r >> FRAC_BITS;
    if (dsh > ONE_EXT) begin
      k_nxt = '0;
    end else begin
      k_nxt = KW'(ONE_EXT - dsh);
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
  end

  assign k_factor = k_r;

endmodule

### rtl/core/pei_axis_lane.sv
`timescale 1ns / 1ps
// Six-stage pipeline for one axis: gravity, drag scaling, position update.
// Depends on pei_pkg for widths and the saturation helper.
module pei_axis_lane #(
  parameter int FRAC_BITS = pei_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [pei_pkg::DT_W-1:0]          dt,
  input  logic signed [pei_pkg::VAL_W-1:0]  pos_in,
  input  logic signed [pei_pkg::VAL_W-1:0]  vel_in,
  input  logic signed [pei_pkg::VAL_W-1:0]  grav_in,
  input  logic [FRAC_BITS:0]                k_factor,
  input  logic                              alive_s5,
  output logic signed [pei_pkg::VAL_W-1:0]  pos_out,
  output logic signed [pei_pkg::VAL_W-1:0]  vel_out
);

  localparam int VW  = pei_pkg::VAL_W;
  localparam int DTS = pei_pkg::DT_W + 1;
  localparam int GPW = VW + DTS;
  localparam int KPW = VW + FRAC_BITS + 2;

  logic signed [DTS-1:0] dts;

  // Original position and velocity travel with the item for dead particles.
  logic signed [VW-1:0]  pos_r   [pei_pkg::PIPE_DEPTH-1];
  logic signed [VW-1:0]  vel_r   [pei_pkg::PIPE_DEPTH-1];
  logic signed [GPW-1:0] gprod_r;
  logic signed [VW-1:0]  vel1_r;
  logic signed [KPW-1:0] kprod_r;
  logic signed [VW-1:0]  vel2_r;
  logic signed [VW-1:0]  vel3_r;
  logic signed [GPW-1:0] pprod_r;
  logic signed [VW-1:0]  pos_new;
  logic signed [VW-1:0]  pos_out_r;
  logic signed [VW-1:0]  vel_out_r;

  assign dts = $signed({1'b0, dt});

  // Carry the original record alongside the arithmetic.
  always_ff @(posedge clk) begin
    pos_r[0] <= pos_in;
    vel_r[0] <= vel_in;
    for (int i = 1; i < pei_pkg::PIPE_DEPTH - 1; i++) begin
      pos_r[i] <= pos_r[i-1];
      vel_r[i] <= vel_r[i-1];
    end
  end

  // Stage one: gravity times time step.
  always_ff @(posedge clk) begin
    gprod_r <= grav_in * dts;
  end

  // Stage two: velocity gains the floored gravity term, saturated.
  always_ff @(posedge clk) begin
    vel1_r <= pei_pkg::sat32(64'(vel_r[0]) + 64'(gprod_r >>> FRAC_BITS));
  end

  // Stage three: velocity times drag factor.
  always_ff @(posedge clk) begin
    kprod_r <= vel1_r * $signed({1'b0, k_factor});
  end

  // Stage four: floor back to the fixed-point scale, saturated.
  always_ff @(posedge clk) begin
    vel2_r <= pei_pkg::sat32(64'(kprod_r >>> FRAC_BITS));
  end

  // Stage five: displacement over one step.
  always_ff @(posedge clk) begin
    pprod_r <= vel2_r * dts;
    vel3_r  <= vel2_r;
  end

  // Stage six: position update, then choose new or unchanged record.
  assign pos_new = pei_pkg::sat32(64'(pos_r[4]) + 64'(pprod_r >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (alive_s5) begin
      pos_out_r <= pos_new;
      vel_out_r <= vel3_r;
    end else begin
      pos_out_r <= pos_r[4];
      vel_out_r <= vel_r[4];
    end
  end

  assign pos_out = pos_out_r;
  assign vel_out = vel_out_r;

endmodule

### rtl/core/particle_euler_integrator.sv
`timescale 1ns / 1ps
// Top level of the particle Euler integrator: time step register, age check
// and control pipeline. Depends on pei_pkg, pei_drag_factor and pei_axis_lane.

// The block takes one particle record every clock cycle: busy is always low,
// so an item is accepted at any edge with start high. Each item gives exactly
// one result, shown with out_strobe for one cycle once the item has passed
// the six register stages of each axis lane (gravity multiply, velocity add,
// drag multiply, rescale, displacement multiply, position add); results leave
// in the order the items came. The receiver must take a result in the cycle
// it is shown. Write time_step through cfg_we and cfg_wdata only while no
// item is in flight.
module particle_euler_integrator #(
  parameter int FRAC_BITS = pei_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  pei_pkg::in_item_t           in_item,
  output logic                        out_strobe,
  output pei_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [pei_pkg::DT_W-1:0]    cfg_wdata
);

  localparam int DEPTH = pei_pkg::PIPE_DEPTH;
  localparam int AW    = pei_pkg::AGE_W;

  logic [pei_pkg::DT_W-1:0] time_step_r;
  logic                     in_accept;
  logic [AW:0]              age_sum;
  logic [AW-1:0]            age_sat;
  logic                     alive_nxt;
  logic [DEPTH-1:0]         valid_r;
  logic [DEPTH-1:0]         alive_r;
  logic [AW-1:0]            age_r [DEPTH];
  logic [FRAC_BITS:0]       k_factor;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // Time step register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= pei_pkg::DT_RESET;
    end else if (cfg_we) begin
      time_step_r <= cfg_wdata;
    end
  end

  // New age saturates at the field range; the particle lives while below lifetime.
  always_comb begin
    age_sum = (AW+1)'(in_item.age_in) + (AW+1)'(time_step_r);
    age_sat = age_sum[AW] ? {AW{1'b1}} : age_sum[AW-1:0];
    alive_nxt = age_sat < in_item.lifetime;
  end

  // Valid bits of the control pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[DEPTH-2:0], in_accept};
    end
  end

  // Age and survival flag travel with each item.
  always_ff @(posedge clk) begin
    alive_r  <= {alive_r[DEPTH-2:0], alive_nxt};
    age_r[0] <= age_sat;
    for (int i = 1; i < DEPTH; i++) begin
      age_r[i] <= age_r[i-1];
    end
  end

  // Drag factor, shared by the three axes.
  pei_drag_factor #(
    .FRAC_BITS (FRAC_BITS)
  ) u_drag (
    .clk       (clk),
    .drag_coef (in_item.drag_coef),
    .dt        (time_step_r),
    .k_factor  (k_factor)
  );

  // One lane per axis.
  pei_axis_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_x (
    .clk      (clk),
    .dt       (time_step_r),
    .pos_in   (in_item.pos_x_in),
    .vel_in   (in_item.vel_x_in),
    .grav_in  (in_item.grav_x),
    .k_factor (k_factor),
    .alive_s5 (alive_r[DEPTH-2]),
    .pos_out  (out_item.pos_x_out),
    .vel_out  (out_item.vel_x_out)
  );

  pei_axis_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_y (
    .clk      (clk),
    .dt       (time_step_r),
    .pos_in   (in_item.pos_y_in),
    .vel_in   (in_item.vel_y_in),
    .grav_in  (in_item.grav_y),
    .k_factor (k_factor),
    .alive_s5 (alive_r[DEPTH-2]),
    .pos_out  (out_item.pos_y_out),
    .vel_out  (out_item.vel_y_out)
  );

  pei_axis_lane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lane_z (
    .clk      (clk),
    .dt       (time_step_r),
    .pos_in   (in_item.pos_z_in),
    .vel_in   (in_item.vel_z_in),
    .grav_in  (in_item.grav_z),
    .k_factor (k_factor),
    .alive_s5 (alive_r[DEPTH-2]),
    .pos_out  (out_item.pos_z_out),
    .vel_out  (out_item.vel_z_out)
  );

  // Result strobe and control fields.
  assign out_strobe           = valid_r[DEPTH-1];
  assign out_item.still_alive = alive_r[DEPTH-1];
  assign out_item.age_out     = age_r[DEPTH-1];

`ifndef ASSERT_OFF
  // Every result goes back to an accepted item.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_accept, 6))
    else $error("result strobe without a matching item");

  // A dead particle leaves with its x position unchanged.
  a_dead_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.still_alive) |->
      (out_item.pos_x_out == $past(in_item.pos_x_in, 6)))
    else $error("dead particle position changed");

  // A dead particle leaves with its y velocity unchanged.
  a_dead_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.still_alive) |->
      (out_item.vel_y_out == $past(in_item.vel_y_in, 6)))
    else $error("dead particle velocity changed");

  // Age never goes down across the pipeline.
  a_age_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.age_out >= $past(in_item.age_in, 6)))
    else $error("age decreased");
`endif

endmodule
